@@ rtl/assert_macros.svh @@
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define SSSEQ_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define SSSEQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ssseq_pkg.sv @@
// Types and constants of the supply shutdown sequencer.
package ssseq_pkg;

    localparam int ADC_BITS_DEF = 10;

    localparam int LIMIT_W   = 18;
    localparam int SCALE_W   = 8;
    localparam int MS_W      = 16;
    localparam int CHECKS_W  = 4;
    localparam int CFG_W     = 18;
    localparam int CFG_IDX_W = 3;
    localparam int ELAPSED_W = 8;
    localparam int TIMER_W   = 17;
    localparam int CNT_W     = 4;
    localparam int EVENT_W   = 4;
    localparam int MODE_W    = 2;

    localparam logic [LIMIT_W-1:0]  LIMIT_RST    = LIMIT_W'(7000);
    localparam logic [SCALE_W-1:0]  SCALE_RST    = SCALE_W'(144);
    localparam logic [MS_W-1:0]     HOLD_RST     = MS_W'(30000);
    localparam logic [MS_W-1:0]     INTERVAL_RST = MS_W'(1000);
    localparam logic [CHECKS_W-1:0] CHECKS_RST   = CHECKS_W'(5);

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CURRENT_LIMIT  = 3'd0,
        CFG_CURRENT_SCALE  = 3'd1,
        CFG_HOLD_DELAY     = 3'd2,
        CFG_CHECK_INTERVAL = 3'd3,
        CFG_STABLE_CHECKS  = 3'd4
    } t_cfg_idx;

    typedef enum logic [MODE_W-1:0] {
        MODE_POLL = 2'd0,
        MODE_UP   = 2'd1,
        MODE_DOWN = 2'd2,
        MODE_BAD  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_ACCEPT  = 3'd1,
        PH_CURRENT = 3'd2,
        PH_HOLD    = 3'd3,
        PH_STABLE  = 3'd4,
        PH_CUTOFF  = 3'd5
    } t_phase;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE            = 4'd0,
        EV_BAD_CMD         = 4'd1,
        EV_UP              = 4'd2,
        EV_DOWN_BEGUN      = 4'd3,
        EV_REQ_ACCEPTED    = 4'd4,
        EV_CURRENT_LOW     = 4'd5,
        EV_DELAY_DONE      = 4'd6,
        EV_STABLE          = 4'd7,
        EV_DOWN_CONFIRMED  = 4'd8,
        EV_DOWN_UNCONFIRMED = 4'd9
    } t_event;

    typedef struct packed {
        logic [LIMIT_W-1:0]  current_limit;
        logic [SCALE_W-1:0]  current_scale;
        logic [MS_W-1:0]     hold_delay_ms;
        logic [MS_W-1:0]     check_interval_ms;
        logic [CHECKS_W-1:0] stable_checks;
    } t_cfg;

    typedef struct packed {
        t_event event_res;
        logic   supply_enable;
        logic   hold_power;
        logic   busy_res;
    } t_result;

endpackage

@@ rtl/ssseq_in_if.sv @@
// Input channel: commands and polls.
interface ssseq_in_if #(
    parameter int ADC_BITS = 10
);
    import ssseq_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [MODE_W-1:0]    mode;
    logic [ADC_BITS-1:0]  current_sample;
    logic [ELAPSED_W-1:0] elapsed_ms;
    logic                 request_accepted;
    logic                 host_down_seen;

    modport source (
        output valid, mode, current_sample, elapsed_ms, request_accepted, host_down_seen,
        input  ready
    );
    modport sink (
        input  valid, mode, current_sample, elapsed_ms, request_accepted, host_down_seen,
        output ready
    );
endinterface

@@ rtl/ssseq_out_if.sv @@
// Output channel: one result item per input item.
interface ssseq_out_if;
    import ssseq_pkg::*;

    logic               valid;
    logic               ready;
    logic [EVENT_W-1:0] event_res;
    logic               supply_enable;
    logic               hold_power;
    logic               busy_res;

    modport source (
        output valid, event_res, supply_enable, hold_power, busy_res,
        input  ready
    );
    modport sink (
        input  valid, event_res, supply_enable, hold_power, busy_res,
        output ready
    );
endinterface

@@ rtl/ssseq_cfg.sv @@
// Configuration register file of the sequencer.
module ssseq_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ssseq_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ssseq_pkg::CFG_W-1:0]     i_cfg_wdata,
    output ssseq_pkg::t_cfg                 o_cfg
);
    import ssseq_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.current_limit     <= LIMIT_RST;
            r_cfg.current_scale     <= SCALE_RST;
            r_cfg.hold_delay_ms     <= HOLD_RST;
            r_cfg.check_interval_ms <= INTERVAL_RST;
            r_cfg.stable_checks     <= CHECKS_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_CURRENT_LIMIT:  r_cfg.current_limit     <= i_cfg_wdata[LIMIT_W-1:0];
                CFG_CURRENT_SCALE:  r_cfg.current_scale     <= i_cfg_wdata[SCALE_W-1:0];
                CFG_HOLD_DELAY:     r_cfg.hold_delay_ms     <= i_cfg_wdata[MS_W-1:0];
                CFG_CHECK_INTERVAL: r_cfg.check_interval_ms <= i_cfg_wdata[MS_W-1:0];
                CFG_STABLE_CHECKS:  r_cfg.stable_checks     <= i_cfg_wdata[CHECKS_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/ssseq_core.sv @@
// Sequencer state and the single-pass step logic for one item.
module ssseq_core #(
    parameter int ADC_BITS = ssseq_pkg::ADC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ssseq_pkg::t_cfg                 i_cfg,
    input  logic                            i_step,
    input  ssseq_pkg::t_mode                i_mode,
    input  logic [ADC_BITS-1:0]             i_sample,
    input  logic [ssseq_pkg::ELAPSED_W-1:0] i_ms,
    input  logic                            i_accepted,
    input  logic                            i_host_down,
    output ssseq_pkg::t_result              o_result
);
    import ssseq_pkg::*;

    localparam int PROD_W = ADC_BITS + SCALE_W;
    localparam int CMP_W  = (PROD_W > LIMIT_W) ? PROD_W : LIMIT_W;

    t_phase              r_phase,  n_phase;
    logic [TIMER_W-1:0]  r_timer,  n_timer;
    logic [ADC_BITS-1:0] r_ref,    n_ref;
    logic [CNT_W-1:0]    r_count,  n_count;
    logic                r_enable, n_enable;
    logic                r_hold,   n_hold;
    t_event              ev;

    logic [PROD_W-1:0]   prod;
    logic                current_low;
    logic [TIMER_W:0]    timer_sum;
    logic [TIMER_W-1:0]  timer_adv;
    logic                hold_done;
    logic                check_due;
    logic                ref_zero;
    logic [ADC_BITS:0]   sample_x;
    logic [ADC_BITS:0]   ref_x;
    logic                near;
    logic [CNT_W-1:0]    count_inc;
    logic                stable_hit;
    logic                stable_done;

    assign prod        = PROD_W'(i_sample) * PROD_W'(i_cfg.current_scale);
    assign current_low = CMP_W'(prod) < CMP_W'(i_cfg.current_limit);

    // saturating timer
    assign timer_sum = {1'b0, r_timer} + (TIMER_W+1)'(i_ms);
    assign timer_adv = timer_sum[TIMER_W] ? '1 : timer_sum[TIMER_W-1:0];
    assign hold_done = timer_adv > TIMER_W'(i_cfg.hold_delay_ms);
    assign check_due = timer_adv > TIMER_W'(i_cfg.check_interval_ms);

    // reading counts as stable when within one count of the reference
    assign ref_zero = (r_ref == '0);
    assign sample_x = {1'b0, i_sample};
    assign ref_x    = {1'b0, r_ref};
    assign near     = (sample_x == ref_x)
                   || (sample_x == ref_x + (ADC_BITS+1)'(1))
                   || (ref_x == sample_x + (ADC_BITS+1)'(1));

    assign count_inc   = (r_count == CNT_MAX) ? r_count : r_count + CNT_W'(1);
    assign stable_hit  = count_inc > i_cfg.stable_checks;
    assign stable_done = !ref_zero && check_due && near && stable_hit;

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (i_mode)
            MODE_UP:   n_phase = PH_IDLE;
            MODE_DOWN: n_phase = PH_ACCEPT;
            MODE_BAD:  n_phase = PH_IDLE;
            MODE_POLL: begin
                unique case (r_phase)
                    PH_ACCEPT:  if (i_accepted)  n_phase = PH_CURRENT;
                    PH_CURRENT: if (current_low) n_phase = PH_HOLD;
                    PH_HOLD:    if (hold_done)   n_phase = PH_STABLE;
                    PH_STABLE:  if (stable_done) n_phase = PH_CUTOFF;
                    PH_CUTOFF:  n_phase = PH_IDLE;
                    default: ;
                endcase
            end
        endcase
    end

    // event and datapath
    always_comb begin
        n_timer  = r_timer;
        n_ref    = r_ref;
        n_count  = r_count;
        n_enable = r_enable;
        n_hold   = r_hold;
        ev       = EV_NONE;
        unique case (i_mode)
            MODE_UP: begin
                n_enable = 1'b1;
                ev       = EV_UP;
            end
            MODE_DOWN: ev = EV_DOWN_BEGUN;
            MODE_BAD:  ev = EV_BAD_CMD;
            MODE_POLL: begin
                unique case (r_phase)
                    PH_ACCEPT: begin
                        if (i_accepted) begin
                            n_hold = 1'b1;
                            ev     = EV_REQ_ACCEPTED;
                        end
                    end
                    PH_CURRENT: begin
                        if (current_low) begin
                            n_timer = '0;
                            ev      = EV_CURRENT_LOW;
                        end
                    end
                    PH_HOLD: begin
                        n_timer = timer_adv;
                        if (hold_done) begin
                            n_ref   = '0;
                            n_count = '0;
                            ev      = EV_DELAY_DONE;
                        end
                    end
                    PH_STABLE: begin
                        if (ref_zero) begin
                            // first reading becomes the reference
                            n_ref   = i_sample;
                            n_timer = '0;
                        end else if (check_due) begin
                            if (near) begin
                                n_count = count_inc;
                                if (stable_hit) ev = EV_STABLE;
                            end else begin
                                n_ref   = i_sample;
                                n_count = '0;
                            end
                            n_timer = '0;
                        end else begin
                            n_timer = timer_adv;
                        end
                    end
                    PH_CUTOFF: begin
                        n_hold   = 1'b0;
                        n_enable = 1'b0;
                        ev       = i_host_down ? EV_DOWN_CONFIRMED : EV_DOWN_UNCONFIRMED;
                    end
                    default: ;
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_timer  <= '0;
            r_ref    <= '0;
            r_count  <= '0;
            r_enable <= 1'b0;
            r_hold   <= 1'b0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_timer  <= n_timer;
            r_ref    <= n_ref;
            r_count  <= n_count;
            r_enable <= n_enable;
            r_hold   <= n_hold;
        end
    end

    assign o_result.event_res     = ev;
    assign o_result.supply_enable = n_enable;
    assign o_result.hold_power    = n_hold;
    assign o_result.busy_res      = (n_phase != PH_IDLE);

endmodule

@@ rtl/supply_shutdown_sequencer_top.sv @@
// Supply shutdown sequencer: top level with input and result registers.
//
// i_in carries one item per handshake: a poll (sample, elapsed ms, host flags)
// or an up, down or invalid command. o_out returns exactly one result item per
// input item: the event code, the supply enable level, the power hold level
// and the busy flag after that item.
// Each item is held in the input register, then its result in the result
// register, from which it leaves while o_out.ready is high.
// Throughput: one item per cycle while o_out.ready is high; the step logic
// between the two registers (one ADC_BITS x 8 multiply, a 17-bit add and
// compares) is combinational.
// When o_out stalls the result register holds its item and the input register
// still takes one more item; i_in.ready falls only when both are full.
// Configuration is written through i_cfg_wdata/i_cfg_idx/i_cfg_we, one
// register per cycle; the user must write it only while no item is in flight,
// as the block itself does not enforce this. Synchronous reset (i_rst_n low)
// empties both registers, returns the sequence to idle with the enable and
// hold low, and reloads configuration defaults.
module supply_shutdown_sequencer_top #(
    parameter int ADC_BITS = ssseq_pkg::ADC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    ssseq_in_if.sink                        i_in,
    ssseq_out_if.source                     o_out,
    input  logic                            i_cfg_we,
    input  logic [ssseq_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ssseq_pkg::CFG_W-1:0]     i_cfg_wdata
);
    import ssseq_pkg::*;

    `include "assert_macros.svh"

    t_cfg                 cfg;
    t_result              result;

    logic                 r_in_valid;
    t_mode                r_in_mode;
    logic [ADC_BITS-1:0]  r_in_sample;
    logic [ELAPSED_W-1:0] r_in_ms;
    logic                 r_in_acc;
    logic                 r_in_down;

    logic                 r_out_valid;
    t_result              r_out_res;

    logic                 adv;
    logic                 step;
    logic                 in_take;

    assign adv     = !r_out_valid || o_out.ready;
    assign step    = r_in_valid && adv;
    assign in_take = i_in.valid && i_in.ready;

    assign i_in.ready = !r_in_valid || adv;

    ssseq_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    ssseq_core #(
        .ADC_BITS (ADC_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_step      (step),
        .i_mode      (r_in_mode),
        .i_sample    (r_in_sample),
        .i_ms        (r_in_ms),
        .i_accepted  (r_in_acc),
        .i_host_down (r_in_down),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_mode   <= t_mode'(i_in.mode);
            r_in_sample <= i_in.current_sample;
            r_in_ms     <= i_in.elapsed_ms;
            r_in_acc    <= i_in.request_accepted;
            r_in_down   <= i_in.host_down_seen;
        end
        if (step) begin
            r_out_res <= result;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.event_res     = r_out_res.event_res;
    assign o_out.supply_enable = r_out_res.supply_enable;
    assign o_out.hold_power    = r_out_res.hold_power;
    assign o_out.busy_res      = r_out_res.busy_res;

    `SSSEQ_ASSERT_IMPL(a_cutoff_drops_all,
        o_out.valid && (o_out.event_res == EV_DOWN_CONFIRMED
                        || o_out.event_res == EV_DOWN_UNCONFIRMED),
        !o_out.supply_enable && !o_out.hold_power && !o_out.busy_res,
        "cut-off item left supply, hold or busy set")
    `SSSEQ_ASSERT_IMPL(a_up_enables,
        o_out.valid && o_out.event_res == EV_UP,
        o_out.supply_enable && !o_out.busy_res,
        "up item without enable or with busy")
    `SSSEQ_ASSERT_IMPL(a_accept_holds,
        o_out.valid && (o_out.event_res == EV_REQ_ACCEPTED
                        || o_out.event_res == EV_DOWN_BEGUN),
        o_out.busy_res,
        "sequence item reported not busy")
    `SSSEQ_ASSERT_NEXT(a_in_reg_kept,
        r_in_valid && !adv,
        r_in_valid && $stable(r_in_mode) && $stable(r_in_sample) && $stable(r_in_ms),
        "waiting input item lost or overwritten")

endmodule
